FILE: rtl/sht_pkg.sv
// Shared types, constants and register codes for the servo hatch trajectory unit.
`default_nettype none

package sht_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int REQ_W      = 2;
	localparam int TIME_W     = 32;
	localparam int ANGLE_W    = 8;
	localparam int MS_W       = 16;
	localparam int PULSE_W    = 12;

	localparam logic [ANGLE_W-1:0] MAX_ANGLE = 8'd180;

	// Register reset values
	localparam logic [ANGLE_W-1:0] RST_START_ANGLE  = 8'd90;
	localparam logic [ANGLE_W-1:0] RST_MIDDLE_ANGLE = 8'd0;
	localparam logic [ANGLE_W-1:0] RST_END_ANGLE    = 8'd180;
	localparam logic [MS_W-1:0]    RST_MOVE_TIME    = 16'd500;
	localparam logic [MS_W-1:0]    RST_SWEEP_TIME   = 16'd1000;
	localparam logic [PULSE_W-1:0] RST_NEUTRAL      = 12'd1500;
	localparam logic [PULSE_W-1:0] RST_CONT_PULSE   = 12'd1500;
	localparam logic [PULSE_W-1:0] RST_PULSE        = 12'd1500;

	// Shared divider sizing: dividend holds up to 255 * 65535
	localparam int DIV_NUM_W = 24;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
	localparam int MUL_W     = MS_W + PULSE_W;

	// Angle-to-pulse scaling: product of angle (<= 180) and span (<= 4000) fits MAP_W bits.
	// Multiplying by ceil(2^27 / 180) and dropping 27 bits gives the exact quotient by 180
	// for every product below 780335.
	localparam int               MAP_W       = 20;
	localparam int               RECIP_SHIFT = 27;
	localparam logic [MAP_W-1:0] RECIP_180   = 20'd745655;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_ANGLE,
		REG_MIDDLE_ANGLE,
		REG_END_ANGLE,
		REG_MOVE_TIME,
		REG_SWEEP_TIME,
		REG_NEUTRAL_PULSE,
		REG_CONT_MODE,
		REG_CONT_PULSE
	} reg_idx_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK,
		REQ_START,
		REQ_STOP
	} req_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] start_angle;
		logic [ANGLE_W-1:0] middle_angle;
		logic [ANGLE_W-1:0] end_angle;
		logic [MS_W-1:0]    move_time_ms;
		logic [MS_W-1:0]    sweep_time_ms;
		logic [PULSE_W-1:0] neutral_width;
		logic               continuous_mode;
		logic [PULSE_W-1:0] cont_width;
	} cfg_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse_width;
		logic               pulse_written;
		logic               running;
		logic               path_done;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SEG,
		S_MUL,
		S_DIV1_GO,
		S_DIV1_WAIT,
		S_MAP,
		S_SCALE,
		S_CLAMP,
		S_DONE
	} seq_state_t;

endpackage

`default_nettype wire

FILE: rtl/sht_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module sht_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sht_pkg::div_req_t   req,
	output sht_pkg::div_rsp_t   rsp
);

	localparam int NumW = sht_pkg::DIV_NUM_W;
	localparam int DenW = sht_pkg::DIV_DEN_W;
	localparam int CntW = sht_pkg::DIV_CNT_W;

	logic            busy_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [DenW-1:0] rem_q;
	logic [NumW-1:0] quo_q;
	logic [DenW-1:0] den_q;

	logic [DenW:0]   trial;
	logic            qbit;
	logic [DenW:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[NumW-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit drops safely
			rem_q <= qbit ? diff[DenW-1:0] : trial[DenW-1:0];
			quo_q <= {quo_q[NumW-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

`default_nettype wire

FILE: rtl/sht_seq.sv
// Request sequencer: trajectory state, shared multiplier and result register.
`default_nettype none

module sht_seq #(
	parameter int MIN_PULSE_US = 500,
	parameter int MAX_PULSE_US = 2500
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  sht_pkg::cfg_t                     cfg,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire  [sht_pkg::REQ_W-1:0]         req_type,
	input  wire  [sht_pkg::TIME_W-1:0]        now_ms,
	output logic                              out_valid,
	input  wire                               out_stall,
	output sht_pkg::result_t                  res,
	output sht_pkg::div_req_t                 div_req,
	input  sht_pkg::div_rsp_t                 div_rsp
);

	localparam int AW = sht_pkg::ANGLE_W;
	localparam int MW = sht_pkg::MS_W;
	localparam int PW = sht_pkg::PULSE_W;
	localparam int TW = sht_pkg::TIME_W;
	localparam int XW = sht_pkg::MAP_W;
	localparam int SpanInt = (MAX_PULSE_US > MIN_PULSE_US) ? (MAX_PULSE_US - MIN_PULSE_US) : 0;
	localparam logic [PW-1:0] Span = PW'(SpanInt);
	localparam logic [PW:0]   MinP = (PW + 1)'(MIN_PULSE_US);
	localparam logic [PW:0]   MaxP = (PW + 1)'(MAX_PULSE_US);

	sht_pkg::seq_state_t state_q, state_d;

	// control and architectural state
	logic            active_q;
	logic [TW-1:0]   start_time_q;
	logic [PW-1:0]   pulse_q;
	logic            out_valid_q;

	// working registers
	logic [sht_pkg::REQ_W-1:0] req_q;
	logic [TW-1:0]   now_q;
	logic [TW-1:0]   phase_q;
	logic [AW-1:0]   from_q;
	logic            up_q;
	logic [AW-1:0]   diff_q;
	logic [MW-1:0]   local_q;
	logic [MW-1:0]   dur_q;
	logic [AW-1:0]   angle_q;
	logic [sht_pkg::DIV_NUM_W-1:0] prod_q;
	logic [PW:0]     raw_q;
	logic            written_q;
	sht_pkg::result_t res_q;

	logic            accept;
	logic            load_out;
	logic [TW-1:0]   phase_now;
	logic [MW:0]     path_len;
	logic            in_seg1;
	logic            in_seg2;
	logic [AW-1:0]   seg_from;
	logic [AW-1:0]   seg_to;
	logic [MW-1:0]   seg_local;
	logic [MW-1:0]   seg_dur;
	logic [MW-1:0]   mul_a;
	logic [PW-1:0]   mul_b;
	logic [sht_pkg::MUL_W-1:0] prod_w;
	logic [2*XW-1:0] scale_w;
	logic [AW-1:0]   angle_c;
	logic [AW-1:0]   interp_w;
	logic [PW-1:0]   clamp_w;
	logic            done_w;

	always_comb begin
		phase_now = now_q - start_time_q;
		path_len  = {1'b0, cfg.move_time_ms} + {1'b0, cfg.sweep_time_ms};
		in_seg1   = (phase_q <= TW'(cfg.move_time_ms));
		in_seg2   = (phase_q <= TW'(path_len));
		if (in_seg1) begin
			seg_from  = cfg.start_angle;
			seg_to    = cfg.middle_angle;
			seg_local = phase_q[MW-1:0];
			seg_dur   = cfg.move_time_ms;
		end else begin
			seg_from  = cfg.middle_angle;
			seg_to    = cfg.end_angle;
			seg_local = phase_q[MW-1:0] - cfg.move_time_ms;
			seg_dur   = cfg.sweep_time_ms;
		end

		angle_c = (angle_q > sht_pkg::MAX_ANGLE) ? sht_pkg::MAX_ANGLE : angle_q;
		if (state_q == sht_pkg::S_MAP) begin
			mul_a = MW'(angle_c);
			mul_b = Span;
		end else begin
			mul_a = local_q;
			mul_b = PW'(diff_q);
		end
		prod_w = mul_a * mul_b;

		// divide by 180 through the reciprocal
		scale_w = prod_q[XW-1:0] * sht_pkg::RECIP_180;

		// quotient never exceeds the angle difference
		interp_w = up_q ? (from_q + div_rsp.quo[AW-1:0]) : (from_q - div_rsp.quo[AW-1:0]);

		if (raw_q < MinP) begin
			clamp_w = MinP[PW-1:0];
		end else if (raw_q > MaxP) begin
			clamp_w = MaxP[PW-1:0];
		end else begin
			clamp_w = raw_q[PW-1:0];
		end

		done_w = active_q && !cfg.continuous_mode && (phase_now > TW'(path_len));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sht_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		accept       = 1'b0;
		load_out     = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = prod_q;
		div_req.den   = dur_q;
		unique case (state_q)
			sht_pkg::S_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				if (in_valid) begin
					state_d = sht_pkg::S_DECODE;
				end
			end
			sht_pkg::S_DECODE: begin
				case (req_q)
					sht_pkg::REQ_START: begin
						if (active_q) begin
							state_d = sht_pkg::S_DONE;
						end else if (cfg.continuous_mode) begin
							state_d = sht_pkg::S_CLAMP;
						end else begin
							state_d = sht_pkg::S_MAP;
						end
					end
					sht_pkg::REQ_STOP: state_d = sht_pkg::S_CLAMP;
					sht_pkg::REQ_TICK: begin
						state_d = (active_q && !cfg.continuous_mode) ? sht_pkg::S_SEG
							: sht_pkg::S_DONE;
					end
					default: state_d = sht_pkg::S_DONE;
				endcase
			end
			sht_pkg::S_SEG: begin
				state_d = (!in_seg2 || seg_dur == '0) ? sht_pkg::S_MAP : sht_pkg::S_MUL;
			end
			sht_pkg::S_MUL: state_d = sht_pkg::S_DIV1_GO;
			sht_pkg::S_DIV1_GO: begin
				div_req.start = 1'b1;
				state_d       = sht_pkg::S_DIV1_WAIT;
			end
			sht_pkg::S_DIV1_WAIT: begin
				if (div_rsp.done) begin
					state_d = sht_pkg::S_MAP;
				end
			end
			sht_pkg::S_MAP: state_d = sht_pkg::S_SCALE;
			sht_pkg::S_SCALE: state_d = sht_pkg::S_CLAMP;
			sht_pkg::S_CLAMP: state_d = sht_pkg::S_DONE;
			sht_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = sht_pkg::S_IDLE;
				end
			end
			default: state_d = sht_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			start_time_q <= '0;
			pulse_q      <= sht_pkg::RST_PULSE;
			out_valid_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == sht_pkg::S_DECODE) begin
				if (req_q == sht_pkg::REQ_START && !active_q) begin
					active_q     <= 1'b1;
					start_time_q <= now_q;
				end else if (req_q == sht_pkg::REQ_STOP) begin
					active_q <= 1'b0;
				end
			end
			if (state_q == sht_pkg::S_CLAMP) begin
				pulse_q <= clamp_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			now_q <= now_ms;
		end
		case (state_q)
			sht_pkg::S_DECODE: begin
				written_q <= 1'b0;
				phase_q   <= phase_now;
				angle_q   <= cfg.start_angle;
				raw_q     <= (req_q == sht_pkg::REQ_STOP) ? {1'b0, cfg.neutral_width}
					: {1'b0, cfg.cont_width};
			end
			sht_pkg::S_SEG: begin
				angle_q <= in_seg2 ? seg_to : cfg.end_angle;
				from_q  <= seg_from;
				up_q    <= (seg_to >= seg_from);
				diff_q  <= (seg_to >= seg_from) ? (seg_to - seg_from) : (seg_from - seg_to);
				local_q <= seg_local;
				dur_q   <= seg_dur;
			end
			sht_pkg::S_MUL, sht_pkg::S_MAP: begin
				prod_q <= prod_w[sht_pkg::DIV_NUM_W-1:0];
			end
			sht_pkg::S_DIV1_WAIT: begin
				if (div_rsp.done) begin
					angle_q <= interp_w;
				end
			end
			sht_pkg::S_SCALE: begin
				raw_q <= MinP + (PW + 1)'(scale_w[sht_pkg::RECIP_SHIFT +: PW]);
			end
			sht_pkg::S_CLAMP: written_q <= 1'b1;
			sht_pkg::S_DONE: begin
				if (load_out) begin
					res_q.pulse_width   <= pulse_q;
					res_q.pulse_written <= written_q;
					res_q.running       <= active_q;
					res_q.path_done     <= done_w;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

FILE: rtl/servo_hatch_trajectory_unit.sv
// Top level of the servo hatch trajectory unit: register file and unit wiring.
//
//  channel | direction | handshake            | beat carries
//  --------+-----------+----------------------+-------------------------------
//  in      | into unit | in_valid / in_stall  | req_type, now_ms
//  out     | from unit | out_valid / out_stall| pulse_width, pulse_written,
//          |           |                      | running, path_done
//  cfg     | into unit | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request at a time, from its accepted beat to the next free input slot: a stop or
// continuous-mode start runs DECODE, CLAMP, DONE; a sweep start adds MAP and SCALE; a tick
// that jumps to a segment end adds SEG too, and one inside a moving segment adds MUL, DIV1_GO
// and a wait on the shared divider for all 24 quotient bits; the map to pulse runs in MAP and SCALE.
// Reset leaves the registers at their defaults, the unit stopped and the pulse at 1500.
// A finished result waits in the output register while the next request is taken.
`default_nettype none

module servo_hatch_trajectory_unit #(
	parameter int MIN_PULSE_US = 500,
	parameter int MAX_PULSE_US = 2500
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  [sht_pkg::REQ_W-1:0]           req_type,
	input  wire  [sht_pkg::TIME_W-1:0]          now_ms,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic [sht_pkg::PULSE_W-1:0]         pulse_width,
	output logic                                pulse_written,
	output logic                                running,
	output logic                                path_done,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [sht_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [sht_pkg::CFG_DATA_W-1:0]      cfg_data
);

	sht_pkg::cfg_t     cfg_q;
	sht_pkg::div_req_t div_req;
	sht_pkg::div_rsp_t div_rsp;
	sht_pkg::result_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_angle     <= sht_pkg::RST_START_ANGLE;
			cfg_q.middle_angle    <= sht_pkg::RST_MIDDLE_ANGLE;
			cfg_q.end_angle       <= sht_pkg::RST_END_ANGLE;
			cfg_q.move_time_ms    <= sht_pkg::RST_MOVE_TIME;
			cfg_q.sweep_time_ms   <= sht_pkg::RST_SWEEP_TIME;
			cfg_q.neutral_width   <= sht_pkg::RST_NEUTRAL;
			cfg_q.continuous_mode <= 1'b0;
			cfg_q.cont_width      <= sht_pkg::RST_CONT_PULSE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sht_pkg::REG_START_ANGLE:   cfg_q.start_angle   <= cfg_data[sht_pkg::ANGLE_W-1:0];
				sht_pkg::REG_MIDDLE_ANGLE:  cfg_q.middle_angle  <= cfg_data[sht_pkg::ANGLE_W-1:0];
				sht_pkg::REG_END_ANGLE:     cfg_q.end_angle     <= cfg_data[sht_pkg::ANGLE_W-1:0];
				sht_pkg::REG_MOVE_TIME:     cfg_q.move_time_ms  <= cfg_data[sht_pkg::MS_W-1:0];
				sht_pkg::REG_SWEEP_TIME:    cfg_q.sweep_time_ms <= cfg_data[sht_pkg::MS_W-1:0];
				sht_pkg::REG_NEUTRAL_PULSE: begin
					cfg_q.neutral_width <= cfg_data[sht_pkg::PULSE_W-1:0];
				end
				sht_pkg::REG_CONT_MODE:     cfg_q.continuous_mode <= cfg_data[0];
				sht_pkg::REG_CONT_PULSE: begin
					cfg_q.cont_width <= cfg_data[sht_pkg::PULSE_W-1:0];
				end
				default: ;
			endcase
		end
	end

	sht_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sht_seq #(
		.MIN_PULSE_US (MIN_PULSE_US),
		.MAX_PULSE_US (MAX_PULSE_US)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.div_req   (div_req),
		.div_rsp   (div_rsp)
	);

	assign pulse_width   = res.pulse_width;
	assign pulse_written = res.pulse_written;
	assign running       = res.running;
	assign path_done     = res.path_done;

endmodule

`default_nettype wire

FILE: rtl/sht_chk.sv
// Port-level checker for the servo hatch trajectory unit, bound to the top level.
`default_nettype none

module sht_chk (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            in_valid,
	input wire                            in_stall,
	input wire [sht_pkg::REQ_W-1:0]       req_type,
	input wire [sht_pkg::TIME_W-1:0]      now_ms,
	input wire                            out_valid,
	input wire                            out_stall,
	input wire [sht_pkg::PULSE_W-1:0]     pulse_width,
	input wire                            pulse_written,
	input wire                            running,
	input wire                            path_done
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pulse_width) && $stable(pulse_written)
			&& $stable(running) && $stable(path_done))
		else $error("result beat changed while stalled");

	// a stalled request beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(req_type) && $stable(now_ms))
		else $error("request beat changed while stalled");

	// one request at a time: the unit stalls its input while it decodes a taken beat and in the state that follows
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("request taken while previous one still in progress");

	// a path can only be finished while the sequence runs
	a_done_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && path_done |-> running)
		else $error("path_done reported while not running");

	// a new result is loaded at the end of a request, never from the idle state
	a_load_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in progress");

endmodule

bind servo_hatch_trajectory_unit sht_chk u_sht_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.req_type      (req_type),
	.now_ms        (now_ms),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.pulse_width   (pulse_width),
	.pulse_written (pulse_written),
	.running       (running),
	.path_done     (path_done)
);

`default_nettype wire
